>>> rtl/med3_pkg.sv
`timescale 1ns / 1ps

package med3_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int TAPS          = 9;
    localparam int PIX_W         = 8;
    localparam int FW_W          = 12;
    localparam int FH_W          = 13;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 13;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int MID_DEPTH     = 4;
    localparam int OUT_DEPTH     = 4;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 12'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             flush;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic             last;
    } out_item_t;

    typedef logic [TAPS-1:0][PIX_W-1:0] taps_t;

    typedef struct packed {
        taps_t taps;
        logic  last;
    } sort_item_t;

endpackage

>>> rtl/med3_ram.sv
`timescale 1ns / 1ps

module med3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/med3_fifo.sv
`timescale 1ns / 1ps

module med3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_pop;

    assign do_pop = pop && (level_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (!push && do_pop)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

endmodule

>>> rtl/med3_front.sv
`timescale 1ns / 1ps

module med3_front #(
    parameter int MAX_WIDTH = med3_pkg::MAX_WIDTH_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            push,
    output logic                                            full,
    input  med3_pkg::in_item_t                              in_data,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]                  w_eff,
    input  logic [med3_pkg::FH_W-1:0]                       h_eff,
    input  logic [$clog2(MAX_WIDTH+1)+med3_pkg::FH_W-1:0]   total,
    input  logic                                            restart,
    output logic                                            q_push,
    output med3_pkg::sort_item_t                            q_data,
    input  logic [$clog2(med3_pkg::MID_DEPTH+1)-1:0]        q_level
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int PW    = WW + med3_pkg::FH_W;
    localparam int RW    = med3_pkg::ROW_W;
    localparam int PXW   = med3_pkg::PIX_W;
    localparam int LW    = $clog2(med3_pkg::MID_DEPTH + 1);

    logic [CW-1:0]        col_reg, col_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [PW-1:0]        ocnt_reg, ocnt_next;

    logic                 s1_valid_reg;
    logic [CW-1:0]        s1_x_reg;
    logic [PXW-1:0]       s1_pix_reg;
    logic                 s1_emit_reg;
    logic                 s1_last_reg;
    logic [2:0]           s1_colok_reg;
    logic [2:0]           s1_rowok_reg;
    logic                 byp_valid_reg;
    logic [2*PXW-1:0]     byp_data_reg;
    med3_pkg::taps_t      win_reg;

    logic                 accept;
    logic                 x_nz;
    logic [RW:0]          r14;
    logic [RW:0]          h14;
    logic                 emit;
    logic                 last;
    logic                 wrap;
    logic [PXW-1:0]       pix;
    logic [2:0]           colok;
    logic [2:0]           rowok;

    logic [2*PXW-1:0]     ram_rdata;
    logic [2*PXW-1:0]     lines;
    logic [2*PXW-1:0]     ram_wdata;
    logic [PXW-1:0]       above1;
    logic [PXW-1:0]       above2;
    med3_pkg::taps_t      shifted;
    med3_pkg::taps_t      taps;

    assign accept = push && !full;
    assign full   = ({1'b0, q_level} + {{LW{1'b0}}, s1_valid_reg})
                    >= (LW + 1)'(med3_pkg::MID_DEPTH);

    assign x_nz = (col_reg != '0);
    assign r14  = {1'b0, row_reg};
    assign h14  = {1'b0, h_eff};

    // center sits one row and one pixel behind the incoming position
    always_comb
    begin
        if (x_nz)
        begin
            emit     = (r14 >= (RW + 1)'(1)) && (r14 <= h14);
            rowok[0] = (r14 >= (RW + 1)'(2));
            rowok[2] = (r14 < h14);
            colok[0] = (WW'(col_reg) >= WW'(2));
        end
        else
        begin
            emit     = (r14 >= (RW + 1)'(2)) && (r14 <= h14 + (RW + 1)'(1));
            rowok[0] = (r14 >= (RW + 1)'(3));
            rowok[2] = (r14 <= h14);
            colok[0] = (w_eff >= WW'(2));
        end
        rowok[1] = 1'b1;
        colok[1] = 1'b1;
        colok[2] = x_nz;
    end

    assign pix  = (in_data.flush || (r14 >= h14)) ? '0 : in_data.pixel;
    assign wrap = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign last = emit && (({1'b0, ocnt_reg} + (PW + 1)'(1)) >= {1'b0, total});

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        ocnt_next = ocnt_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            ocnt_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                col_next  = '0;
                row_next  = '0;
                ocnt_next = '0;
            end
            else
            begin
                if (wrap)
                begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
                if (emit)
                begin
                    ocnt_next = ocnt_reg + PW'(1);
                end
            end
        end
    end

    // line store: low byte is the row above, high byte two rows above
    med3_ram #(
        .WIDTH (2 * PXW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_x_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign lines     = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign above1    = lines[PXW-1:0];
    assign above2    = lines[2*PXW-1:PXW];
    assign ram_wdata = {above1, s1_pix_reg};
    assign shifted   = {s1_pix_reg, above1, above2, win_reg[8:3]};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                taps[c*3+r] = (s1_colok_reg[c] && s1_rowok_reg[r]) ? shifted[c*3+r] : '0;
            end
        end
    end

    assign q_push      = s1_valid_reg && s1_emit_reg;
    assign q_data.taps = taps;
    assign q_data.last = s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            ocnt_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            ocnt_reg     <= ocnt_next;
            s1_valid_reg <= accept;
            if (accept)
            begin
                byp_valid_reg <= s1_valid_reg && (s1_x_reg == col_reg);
            end
            if (restart)
            begin
                win_reg <= '0;
            end
            else if (s1_valid_reg)
            begin
                win_reg <= s1_last_reg ? '0 : shifted;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg     <= col_reg;
            s1_pix_reg   <= pix;
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            s1_colok_reg <= colok;
            s1_rowok_reg <= rowok;
            byp_data_reg <= ram_wdata;
        end
    end

endmodule

>>> rtl/med3_back.sv
`timescale 1ns / 1ps

module med3_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  med3_pkg::sort_item_t  q_data,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output med3_pkg::out_item_t   out_data
);

    localparam int CRW = $clog2(med3_pkg::OUT_DEPTH + 1);
    localparam int OW  = $bits(med3_pkg::out_item_t);

    logic [CRW-1:0]       credit_reg, credit_next;
    logic                 p1_valid_reg;
    logic                 p2_valid_reg;
    med3_pkg::taps_t      p1_taps_reg;
    med3_pkg::taps_t      p2_taps_reg;
    logic                 p1_last_reg;
    logic                 p2_last_reg;
    logic                 out_pop;
    med3_pkg::taps_t      fin;
    med3_pkg::out_item_t  res;
    logic [OW-1:0]        res_bits;
    logic [OW-1:0]        head_bits;
    logic [CRW-1:0]       out_level;

    function automatic med3_pkg::taps_t cs(med3_pkg::taps_t t, int a, int b);
        med3_pkg::taps_t o;
        o = t;
        if (t[a] > t[b])
        begin
            o[a] = t[b];
            o[b] = t[a];
        end
        return o;
    endfunction

    // sort each column of three
    function automatic med3_pkg::taps_t net_a(med3_pkg::taps_t t);
        med3_pkg::taps_t o;
        o = cs(t, 1, 2);
        o = cs(o, 4, 5);
        o = cs(o, 7, 8);
        o = cs(o, 0, 1);
        o = cs(o, 3, 4);
        o = cs(o, 6, 7);
        o = cs(o, 1, 2);
        o = cs(o, 4, 5);
        o = cs(o, 7, 8);
        return o;
    endfunction

    function automatic med3_pkg::taps_t net_b(med3_pkg::taps_t t);
        med3_pkg::taps_t o;
        o = cs(t, 0, 3);
        o = cs(o, 5, 8);
        o = cs(o, 4, 7);
        o = cs(o, 3, 6);
        o = cs(o, 1, 4);
        o = cs(o, 2, 5);
        o = cs(o, 4, 7);
        return o;
    endfunction

    function automatic med3_pkg::taps_t net_c(med3_pkg::taps_t t);
        med3_pkg::taps_t o;
        o = cs(t, 4, 2);
        o = cs(o, 6, 4);
        o = cs(o, 4, 2);
        return o;
    endfunction

    assign out_pop = pop && !empty;
    assign q_pop   = !q_empty && (credit_reg < CRW'(med3_pkg::OUT_DEPTH));

    always_comb
    begin
        credit_next = credit_reg;
        if (q_pop && !out_pop)
        begin
            credit_next = credit_reg + CRW'(1);
        end
        else if (!q_pop && out_pop)
        begin
            credit_next = credit_reg - CRW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            p1_valid_reg <= q_pop;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p1_taps_reg <= net_a(q_data.taps);
            p1_last_reg <= q_data.last;
        end
        if (p1_valid_reg)
        begin
            p2_taps_reg <= net_b(p1_taps_reg);
            p2_last_reg <= p1_last_reg;
        end
    end

    assign fin        = net_c(p2_taps_reg);
    assign res.median = fin[4];
    assign res.last   = p2_last_reg;
    assign res_bits   = res;

    med3_fifo #(
        .WIDTH (OW),
        .DEPTH (med3_pkg::OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (p2_valid_reg),
        .din   (res_bits),
        .pop   (out_pop),
        .dout  (head_bits),
        .empty (empty),
        .level (out_level)
    );

    assign out_data = med3_pkg::out_item_t'(head_bits);

endmodule

>>> rtl/median3x3_filter.sv
`timescale 1ns / 1ps
// channel   direction  handshake                   payload
// pixels    in         push / full                 in_data (pixel, flush)
// results   out        pop / empty                 out_data (median, last)
// config    in         psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// one item per cycle sustained while full is low; a result passes the front stage, middle
// queue, sorter and result queue to out_data; the line store takes one read and one write
// per cycle, which sets the item rate; reset clears counters, window and queues; the line
// store itself is never cleared; full rises when the four-entry middle queue could
// overflow; the sorter stalls while four results sit in the sorter or the four-entry result queue

module median3x3_filter #(
    parameter int MAX_WIDTH = med3_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  med3_pkg::in_item_t            in_data,
    output logic                          empty,
    input  logic                          pop,
    output med3_pkg::out_item_t           out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [med3_pkg::ADDR_W-1:0]   paddr,
    input  logic [med3_pkg::DATA_W-1:0]   pwdata,
    output logic [med3_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = med3_pkg::FH_W;
    localparam int PW  = WW + HW;
    localparam int SW  = $bits(med3_pkg::sort_item_t);
    localparam int LW  = $clog2(med3_pkg::MID_DEPTH + 1);

    logic [med3_pkg::FW_W-1:0] fw_reg;
    logic [HW-1:0]             fh_reg;
    logic [WW-1:0]             w_eff_reg;
    logic [HW-1:0]             h_eff_reg;
    logic [PW-1:0]             total_reg;
    logic                      cfg_wr;

    logic                      q_push;
    logic                      q_pop;
    logic                      q_empty;
    logic [LW-1:0]             q_level;
    med3_pkg::sort_item_t      q_in;
    med3_pkg::sort_item_t      q_out;
    logic [SW-1:0]             q_in_bits;
    logic [SW-1:0]             q_out_bits;

    function automatic logic [WW-1:0] clamp_w(logic [med3_pkg::FW_W-1:0] v);
        logic [WW-1:0] r;
        if (v == '0)
        begin
            r = WW'(1);
        end
        else if (32'(v) > 32'(MAX_WIDTH))
        begin
            r = WW'(MAX_WIDTH);
        end
        else
        begin
            r = WW'(v);
        end
        return r;
    endfunction

    function automatic logic [HW-1:0] clamp_h(logic [HW-1:0] v);
        logic [HW-1:0] r;
        if (v == '0)
        begin
            r = HW'(1);
        end
        else if (32'(v) > 32'(med3_pkg::MAX_HEIGHT))
        begin
            r = HW'(med3_pkg::MAX_HEIGHT);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg    <= med3_pkg::FW_RESET;
            fh_reg    <= med3_pkg::FH_RESET;
            w_eff_reg <= clamp_w(med3_pkg::FW_RESET);
            h_eff_reg <= clamp_h(med3_pkg::FH_RESET);
            total_reg <= PW'(clamp_w(med3_pkg::FW_RESET)) * PW'(clamp_h(med3_pkg::FH_RESET));
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    med3_pkg::REG_FRAME_WIDTH:
                    begin
                        fw_reg    <= pwdata[med3_pkg::FW_W-1:0];
                        w_eff_reg <= clamp_w(pwdata[med3_pkg::FW_W-1:0]);
                    end
                    med3_pkg::REG_FRAME_HEIGHT:
                    begin
                        fh_reg    <= pwdata[HW-1:0];
                        h_eff_reg <= clamp_h(pwdata[HW-1:0]);
                    end
                    default:
                    begin
                        fw_reg <= fw_reg;
                    end
                endcase
            end
            total_reg <= PW'(w_eff_reg) * PW'(h_eff_reg);
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            med3_pkg::REG_FRAME_WIDTH:  prdata = med3_pkg::DATA_W'(fw_reg);
            med3_pkg::REG_FRAME_HEIGHT: prdata = med3_pkg::DATA_W'(fh_reg);
            default:                    prdata = '0;
        endcase
    end

    med3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_data (in_data),
        .w_eff   (w_eff_reg),
        .h_eff   (h_eff_reg),
        .total   (total_reg),
        .restart (cfg_wr),
        .q_push  (q_push),
        .q_data  (q_in),
        .q_level (q_level)
    );

    assign q_in_bits = q_in;

    med3_fifo #(
        .WIDTH (SW),
        .DEPTH (med3_pkg::MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in_bits),
        .pop   (q_pop),
        .dout  (q_out_bits),
        .empty (q_empty),
        .level (q_level)
    );

    assign q_out = med3_pkg::sort_item_t'(q_out_bits);

    med3_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

endmodule

>>> rtl/med3_checker.sv
`timescale 1ns / 1ps

module med3_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          push,
    input logic                          full,
    input med3_pkg::in_item_t            in_data,
    input logic                          empty,
    input logic                          pop,
    input med3_pkg::out_item_t           out_data,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [med3_pkg::ADDR_W-1:0]   paddr,
    input logic [med3_pkg::DATA_W-1:0]   pwdata,
    input logic [med3_pkg::DATA_W-1:0]   prdata,
    input logic                          pready
);

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> (empty && !full))
        else $error("queues not idle in reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_data)))
        else $error("waiting result changed");

    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[2] == med3_pkg::REG_FRAME_WIDTH)
        |=> (pwrite || paddr[2] != med3_pkg::REG_FRAME_WIDTH
             || prdata[11:0] == $past(pwdata[11:0])))
        else $error("frame width readback mismatch");

    a_height_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[2] == med3_pkg::REG_FRAME_HEIGHT)
        |=> (pwrite || paddr[2] != med3_pkg::REG_FRAME_HEIGHT
             || prdata[12:0] == $past(pwdata[12:0])))
        else $error("frame height readback mismatch");

endmodule

bind median3x3_filter med3_checker u_med3_checker (.*);
